>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the UV sphere vertex generator.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define UVS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("uvs assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define UVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uvs assertion failed");
`else
`define UVS_ASSERT(label, clk, rst, prop)
`define UVS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/uvs_pkg.sv
// Package of the UV sphere vertex generator: constants, payload types and
// the rounded Q30 multiply. No dependencies.
`default_nettype none

package uvs_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int COORD_SHIFT = 30 - FRAC_BITS;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] Q30_HALF    = 31'h2000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Phase divider: one quotient bit per step, several steps per stage.
  localparam int DIV_STAGES          = 10;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DVD_W               = DIV_STAGES * DIV_STEPS_PER_STAGE;

  // Taylor series: lane 0 is the sine, lane 1 the cosine.
  localparam int SER_LANES = 2;
  localparam int SER_STEPS = 4;
  localparam int SER_K [SER_LANES][SER_STEPS] = '{'{72, 42, 20, 6}, '{90, 56, 30, 12}};
  localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;
  localparam logic [31:0] SER_RECIP [SER_LANES][SER_STEPS] = '{
    '{32'(TWO_POW_32 / 72), 32'(TWO_POW_32 / 42), 32'(TWO_POW_32 / 20), 32'(TWO_POW_32 / 6)},
    '{32'(TWO_POW_32 / 90), 32'(TWO_POW_32 / 56), 32'(TWO_POW_32 / 30), 32'(TWO_POW_32 / 12)}
  };

  // Divider, fold, angle multiply, square, series (four registers per step),
  // two finishing stages, quadrant.
  localparam int ANGLE_LAT  = DIV_STAGES + 3 + 4 * SER_STEPS + 3;
  localparam int PIPE_DEPTH = ANGLE_LAT + 2;

  typedef enum logic [1:0] {
    REG_RING_COUNT    = 2'd0,
    REG_SEGMENT_COUNT = 2'd1,
    REG_NORMAL_ENABLE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [7:0] ring_index;
    logic [7:0] segment_index;
  } point_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        tri_a0;
    logic [15:0]        tri_a1;
    logic [15:0]        tri_a2;
    logic [15:0]        tri_b0;
    logic [15:0]        tri_b1;
    logic [15:0]        tri_b2;
    logic               indices_valid;
    logic               has_normal;
    logic               out_of_range;
  } vertex_t;

  // Sign-magnitude sine and cosine of one angle, Q30.
  typedef struct packed {
    logic [30:0] sm;
    logic        sn;
    logic [30:0] cm;
    logic        cn;
  } trig_t;

  function automatic logic [30:0] qmul(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + 62'(Q30_HALF);
    return p[60:30];
  endfunction

endpackage

`default_nettype wire

>>> sv/uvs_angle.sv
// Pipelined sine and cosine of the angle num/den of a turn (Q30 results).
// Depends on uvs_pkg; every stage advances only when en is high.
`default_nettype none

module uvs_angle import uvs_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] num,
  input  logic [8:0] den,
  output trig_t      trig
);

  typedef struct packed {
    logic [8:0]       rem;
    logic [DVD_W-1:0] dvd;
    logic [31:0]      quo;
    logic [8:0]       den;
  } div_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } ctx_t;

  localparam int CTX_LAST = 4 * SER_STEPS;

  function automatic div_t div_step(input div_t d);
    div_t       o;
    logic [9:0] r;
    o = d;
    for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
      r     = {o.rem, o.dvd[DVD_W-1]};
      o.dvd = {o.dvd[DVD_W-2:0], 1'b0};
      if (r >= {1'b0, o.den}) begin
        r     = r - {1'b0, o.den};
        o.quo = {o.quo[30:0], 1'b1};
      end else begin
        o.quo = {o.quo[30:0], 1'b0};
      end
      o.rem = r[8:0];
    end
    return o;
  endfunction

  div_t        div_in;
  div_t        div_q [DIV_STAGES];
  logic [31:0] phase;

  logic [29:0] r_f1;
  logic [1:0]  quad_f1;
  logic        swap_f1;
  logic [60:0] xp;
  logic [29:0] x_f2;
  logic [1:0]  quad_f2;
  logic        swap_f2;

  ctx_t        ctx_s [CTX_LAST+1];
  logic [30:0] ser_p  [SER_LANES][SER_STEPS];
  logic [30:0] ser_ap [SER_LANES][SER_STEPS];
  logic [30:0] ser_qe [SER_LANES][SER_STEPS];
  logic [30:0] ser_t  [SER_LANES][SER_STEPS];
  logic [30:0] t_in   [SER_LANES][SER_STEPS];
  logic [30:0] q_fix  [SER_LANES][SER_STEPS];
  logic [62:0] qprod  [SER_LANES][SER_STEPS];
  logic [31:0] qrem   [SER_LANES][SER_STEPS];

  logic [30:0] s_s1, pc_s1, s_s2, c_s2, s_sel, c_sel;
  ctx_t        ctx_s1, ctx_s2;

  // The dividend is num * 2^32 plus half the divisor, so the quotient rounds.
  assign div_in = '{rem: 9'd0, dvd: {num, 24'd0, den[8:1]}, quo: 32'd0, den: den};
  assign phase  = div_q[DIV_STAGES-1].quo;

  always_ff @(posedge clk) begin
    if (en) begin
      div_q[0] <= div_step(div_in);
      for (int k = 1; k < DIV_STAGES; k++) begin
        div_q[k] <= div_step(div_q[k-1]);
      end
    end
  end

  // Fold the quarter turn to an octant, then scale to radians.
  assign xp = 61'(r_f1) * 61'(HALF_PI_Q30) + 61'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      quad_f1 <= phase[31:30];
      if (phase[29:0] > 30'h2000_0000) begin
        r_f1    <= 30'(Q30_ONE - {1'b0, phase[29:0]});
        swap_f1 <= 1'b1;
      end else begin
        r_f1    <= phase[29:0];
        swap_f1 <= 1'b0;
      end
      x_f2           <= xp[59:30];
      quad_f2        <= quad_f1;
      swap_f2        <= swap_f1;
      ctx_s[0].x     <= x_f2;
      ctx_s[0].x2    <= 30'(qmul({1'b0, x_f2}, {1'b0, x_f2}));
      ctx_s[0].quad  <= quad_f2;
      ctx_s[0].swap  <= swap_f2;
      for (int k = 1; k <= CTX_LAST; k++) begin
        ctx_s[k] <= ctx_s[k-1];
      end
    end
  end

  // Each series step is t = 1 - round(x2 * t / k): multiply, reciprocal
  // multiply, then one correction of the quotient estimate.
  always_comb begin
    for (int l = 0; l < SER_LANES; l++) begin
      for (int j = 0; j < SER_STEPS; j++) begin
        t_in[l][j]  = (j == 0) ? Q30_ONE : ser_t[l][(j == 0) ? 0 : j-1];
        qprod[l][j] = 63'(ser_ap[l][j]) * 63'(SER_RECIP[l][j]);
        qrem[l][j]  = 32'(ser_ap[l][j]) - 32'(ser_qe[l][j]) * 32'(SER_K[l][j]);
        q_fix[l][j] = ser_qe[l][j] + {30'd0, qrem[l][j] >= 32'(SER_K[l][j])};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < SER_LANES; l++) begin
        for (int j = 0; j < SER_STEPS; j++) begin
          ser_p[l][j]  <= qmul({1'b0, ctx_s[4*j].x2}, t_in[l][j]);
          ser_ap[l][j] <= ser_p[l][j] + 31'(SER_K[l][j] / 2);
          ser_qe[l][j] <= qprod[l][j][62:32];
          ser_t[l][j]  <= Q30_ONE - q_fix[l][j];
        end
      end
    end
  end

  always_comb begin
    s_sel = ctx_s2.swap ? c_s2 : s_s2;
    c_sel = ctx_s2.swap ? s_s2 : c_s2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_s1   <= qmul({1'b0, ctx_s[CTX_LAST].x}, ser_t[0][SER_STEPS-1]);
      pc_s1  <= qmul({1'b0, ctx_s[CTX_LAST].x2}, ser_t[1][SER_STEPS-1]);
      ctx_s1 <= ctx_s[CTX_LAST];
      s_s2   <= s_s1;
      c_s2   <= Q30_ONE - 31'((32'(pc_s1) + 32'd1) >> 1);
      ctx_s2 <= ctx_s1;
      case (ctx_s2.quad)
        2'd0:    trig <= '{sm: s_sel, sn: 1'b0, cm: c_sel, cn: 1'b0};
        2'd1:    trig <= '{sm: c_sel, sn: 1'b0, cm: s_sel, cn: 1'b1};
        2'd2:    trig <= '{sm: s_sel, sn: 1'b1, cm: c_sel, cn: 1'b1};
        default: trig <= '{sm: c_sel, sn: 1'b1, cm: s_sel, cn: 1'b0};
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/uv_sphere_vertex_index_gen_unit.sv
// Top level of the UV sphere vertex and index generator.
// Depends on uvs_pkg, uvs_angle and assert_macros.svh.
//
// Usage: a request on the point channel carries one (ring, segment) grid
// point; the vertex channel returns its Q2.14 position, the six triangle
// indices of the quad it owns and three flags. Both channels use valid and
// ready. The APB port holds ring_count (0x0), segment_count (0x4) and
// normal_enable (0x8); write it only while no request is in flight.
// One point is accepted every cycle while the receiver is not stalling. The
// pipeline depth is set by the ten-stage phase divider and the stages of the
// series evaluation for the two angles.
// The whole pipeline advances together: when the receiver stalls with a
// result waiting, every stage holds and point_ready drops until the result is
// taken. Reset clears the stage valid bits and loads the register defaults
// (16 rings, 16 segments, no normal); there is no memory to clear.
`default_nettype none
`include "assert_macros.svh"

module uv_sphere_vertex_index_gen_unit import uvs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        point_valid,
  output logic        point_ready,
  input  point_t      point,
  output logic        vertex_valid,
  input  logic        vertex_ready,
  output vertex_t     vertex
);

  typedef struct packed {
    logic [15:0] base;
    logic [7:0]  sc;
    logic        oor;
    logic        ok;
    logic        has_normal;
  } meta_t;

  typedef struct packed {
    logic [30:0] xm;
    logic        xn;
    logic [30:0] ym;
    logic        yn;
    logic [30:0] zm;
    logic        zn;
    meta_t       meta;
  } prod_t;

  localparam logic [31:0] COORD_RND = (COORD_SHIFT > 0) ? (32'd1 << (COORD_SHIFT - 1)) : 32'd0;

  function automatic logic [15:0] to_coord(input logic [30:0] m, input logic neg);
    logic [31:0] r;
    r = ({1'b0, m} + COORD_RND) >> COORD_SHIFT;
    if (!neg) begin
      return (r > 32'd32767) ? 16'h7FFF : r[15:0];
    end else if (r > 32'd32768) begin
      return 16'h8000;
    end else begin
      return 16'(17'h1_0000 - r[16:0]);
    end
  endfunction

  logic [7:0] ring_count, segment_count;
  logic       normal_enable;
  logic       cfg_write;
  logic [7:0] rc, sc;
  logic       en;
  logic       v [PIPE_DEPTH];
  meta_t      meta_in;
  meta_t      meta_d [ANGLE_LAT];
  trig_t      theta, phi;
  prod_t      prod;
  meta_t      pm;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count    <= 8'd16;
      segment_count <= 8'd16;
      normal_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(paddr[3:2]))
        REG_RING_COUNT:    ring_count    <= pwdata[7:0];
        REG_SEGMENT_COUNT: segment_count <= pwdata[7:0];
        REG_NORMAL_ENABLE: normal_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[3:2]))
      REG_RING_COUNT:    prdata = {24'd0, ring_count};
      REG_SEGMENT_COUNT: prdata = {24'd0, segment_count};
      REG_NORMAL_ENABLE: prdata = {31'd0, normal_enable};
      default:           prdata = 32'd0;
    endcase
  end

  // A zero count behaves as a count of one.
  assign rc = (ring_count == 8'd0) ? 8'd1 : ring_count;
  assign sc = (segment_count == 8'd0) ? 8'd1 : segment_count;

  assign en          = !v[PIPE_DEPTH-1] || vertex_ready;
  assign point_ready = en;

  always_comb begin
    meta_in.oor        = (point.ring_index > rc) || (point.segment_index > sc);
    meta_in.ok         = !meta_in.oor && (point.ring_index < rc);
    meta_in.base       = 16'(17'(point.ring_index) * 17'({1'b0, sc} + 9'd1)
                             + 17'(point.segment_index));
    meta_in.sc         = sc;
    meta_in.has_normal = normal_enable;
  end

  uvs_angle u_theta (
    .clk  (clk),
    .en   (en),
    .num  (point.ring_index),
    .den  ({rc, 1'b0}),
    .trig (theta)
  );

  uvs_angle u_phi (
    .clk  (clk),
    .en   (en),
    .num  (point.segment_index),
    .den  ({1'b0, sc}),
    .trig (phi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        v[k] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= point_valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_d[0] <= meta_in;
      for (int k = 1; k < ANGLE_LAT; k++) begin
        meta_d[k] <= meta_d[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod.xm   <= qmul(theta.sm, phi.sm);
      prod.xn   <= theta.sn ^ phi.sn;
      prod.ym   <= theta.cm;
      prod.yn   <= theta.cn;
      prod.zm   <= qmul(theta.sm, phi.cm);
      prod.zn   <= theta.sn ^ phi.cn;
      prod.meta <= meta_d[ANGLE_LAT-1];
    end
  end

  assign pm = prod.meta;

  always_ff @(posedge clk) begin
    if (en) begin
      vertex.pos_x         <= pm.oor ? 16'sd0 : to_coord(prod.xm, prod.xn);
      vertex.pos_y         <= pm.oor ? 16'sd0 : to_coord(prod.ym, prod.yn);
      vertex.pos_z         <= pm.oor ? 16'sd0 : to_coord(prod.zm, prod.zn);
      vertex.tri_a0        <= pm.ok ? pm.base + {8'd0, pm.sc} + 16'd1 : 16'd0;
      vertex.tri_a1        <= pm.ok ? pm.base : 16'd0;
      vertex.tri_a2        <= pm.ok ? pm.base + {8'd0, pm.sc} : 16'd0;
      vertex.tri_b0        <= pm.ok ? pm.base + {8'd0, pm.sc} + 16'd1 : 16'd0;
      vertex.tri_b1        <= pm.ok ? pm.base + 16'd1 : 16'd0;
      vertex.tri_b2        <= pm.ok ? pm.base : 16'd0;
      vertex.indices_valid <= pm.ok;
      vertex.has_normal    <= pm.has_normal;
      vertex.out_of_range  <= pm.oor;
    end
  end

  assign vertex_valid = v[PIPE_DEPTH-1];

  `UVS_ASSERT(a_oor_clears, clk, rst, vertex_valid && vertex.out_of_range |-> !vertex.indices_valid && vertex.pos_x == 16'sd0 && vertex.pos_y == 16'sd0 && vertex.pos_z == 16'sd0)
  `UVS_ASSERT(a_idx_zero, clk, rst, vertex_valid && !vertex.indices_valid |-> vertex.tri_a1 == 16'd0 && vertex.tri_b0 == 16'd0)
  `UVS_ASSERT_NEXT(a_accept_fills, clk, rst, point_valid && point_ready, v[0])
  `UVS_ASSERT_NEXT(a_stall_holds, clk, rst, v[ANGLE_LAT] && !en, v[ANGLE_LAT])

endmodule

`default_nettype wire
